// ----- sv/lcr_pkg.sv -----
// Shared constants and register codes for the line clipper.
package lcr_pkg;

  localparam int COORD_BITS_DEF = 10;

  localparam int LEFT_RST   = 100;
  localparam int RIGHT_RST  = 400;
  localparam int TOP_RST    = 100;
  localparam int BOTTOM_RST = 400;

  localparam int CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LEFT   = 2'd0,
    REG_RIGHT  = 2'd1,
    REG_TOP    = 2'd2,
    REG_BOTTOM = 2'd3
  } cfg_reg_t;

endpackage

// ----- sv/lcr_setup.sv -----
// First stage: per-axis entry/exit fractions and parallel-edge rejects.
module lcr_setup #(
  parameter int N = lcr_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [N-1:0]        win_left,
  input  logic [N-1:0]        win_right,
  input  logic [N-1:0]        win_top,
  input  logic [N-1:0]        win_bottom,
  input  logic [N-1:0]        x1,
  input  logic [N-1:0]        y1,
  input  logic [N-1:0]        x2,
  input  logic [N-1:0]        y2,
  output logic                s1_valid,
  output logic signed [N+1:0] xen_num,
  output logic signed [N+1:0] xex_num,
  output logic signed [N+1:0] x_den,
  output logic                x_has,
  output logic signed [N+1:0] yen_num,
  output logic signed [N+1:0] yex_num,
  output logic signed [N+1:0] y_den,
  output logic                y_has,
  output logic                rej,
  output logic signed [N+1:0] bx,
  output logic signed [N+1:0] by,
  output logic signed [N+1:0] ddx,
  output logic signed [N+1:0] ddy
);
  import lcr_pkg::*;

  logic signed [N+1:0] sx1, sy1, dx, dy;
  logic signed [N+1:0] lo_qx, hi_qx, lo_qy, hi_qy;
  logic signed [N+1:0] xen_next, xex_next, xden_next, yen_next, yex_next, yden_next;
  logic                rej_next;

  always_comb begin
    sx1   = signed'({2'b00, x1});
    sy1   = signed'({2'b00, y1});
    dx    = signed'({2'b00, x2}) - sx1;
    dy    = signed'({2'b00, y2}) - sy1;
    lo_qx = sx1 - signed'({2'b00, win_left});
    hi_qx = signed'({2'b00, win_right}) - sx1;
    lo_qy = sy1 - signed'({2'b00, win_top});
    hi_qy = signed'({2'b00, win_bottom}) - sy1;

    // moving toward +x enters at the low edge, toward -x at the high edge
    if (dx[N+1]) begin
      xen_next  = -hi_qx;
      xex_next  = lo_qx;
      xden_next = -dx;
    end else begin
      xen_next  = -lo_qx;
      xex_next  = hi_qx;
      xden_next = dx;
    end
    if (dy[N+1]) begin
      yen_next  = -hi_qy;
      yex_next  = lo_qy;
      yden_next = -dy;
    end else begin
      yen_next  = -lo_qy;
      yex_next  = hi_qy;
      yden_next = dy;
    end
    rej_next = ((dx == '0) && (lo_qx[N+1] || hi_qx[N+1])) ||
               ((dy == '0) && (lo_qy[N+1] || hi_qy[N+1]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xen_num <= xen_next;
      xex_num <= xex_next;
      x_den   <= xden_next;
      x_has   <= (dx != '0);
      yen_num <= yen_next;
      yex_num <= yex_next;
      y_den   <= yden_next;
      y_has   <= (dy != '0);
      rej     <= rej_next;
      bx      <= sx1;
      by      <= sy1;
      ddx     <= dx;
      ddy     <= dy;
    end
  end

endmodule

// ----- sv/lcr_param.sv -----
// Stages two to five: pick t_enter/t_exit, visibility, point numerators.
module lcr_param #(
  parameter int N = lcr_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                s1_valid,
  input  logic signed [N+1:0] xen_num,
  input  logic signed [N+1:0] xex_num,
  input  logic signed [N+1:0] x_den,
  input  logic                x_has,
  input  logic signed [N+1:0] yen_num,
  input  logic signed [N+1:0] yex_num,
  input  logic signed [N+1:0] y_den,
  input  logic                y_has,
  input  logic                rej,
  input  logic signed [N+1:0] bx,
  input  logic signed [N+1:0] by,
  input  logic signed [N+1:0] ddx,
  input  logic signed [N+1:0] ddy,
  output logic                s5_valid,
  output logic                s5_vis,
  output logic [2*N-1:0]      n_sx,
  output logic [2*N-1:0]      n_sy,
  output logic [2*N-1:0]      n_ex,
  output logic [2*N-1:0]      n_ey,
  output logic [N-1:0]        en_den_o,
  output logic [N-1:0]        ex_den_o
);
  import lcr_pkg::*;

  localparam int W  = N + 2;
  localparam int PW = 2 * N + 4;

  // stage 2: clamp against 0 and 1, cross products for the two compares
  logic signed [W-1:0]  aenx_n, aenx_d, aeny_n, aeny_d;
  logic signed [W-1:0]  aexx_n, aexx_d, aexy_n, aexy_d;
  logic signed [W-1:0]  one;
  logic                 v2, rej2;
  logic signed [W-1:0]  enx_n2, enx_d2, eny_n2, eny_d2;
  logic signed [W-1:0]  exx_n2, exx_d2, exy_n2, exy_d2;
  logic signed [W-1:0]  bx2, by2, dx2, dy2;
  logic signed [PW-1:0] pe_a, pe_b, px_a, px_b;

  always_comb begin
    one = W'(1);
    if (x_has && (xen_num > 0)) begin
      aenx_n = xen_num; aenx_d = x_den;
    end else begin
      aenx_n = '0;      aenx_d = one;
    end
    if (y_has && (yen_num > 0)) begin
      aeny_n = yen_num; aeny_d = y_den;
    end else begin
      aeny_n = '0;      aeny_d = one;
    end
    if (x_has && (xex_num < x_den)) begin
      aexx_n = xex_num; aexx_d = x_den;
    end else begin
      aexx_n = one;     aexx_d = one;
    end
    if (y_has && (yex_num < y_den)) begin
      aexy_n = yex_num; aexy_d = y_den;
    end else begin
      aexy_n = one;     aexy_d = one;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      enx_n2 <= aenx_n; enx_d2 <= aenx_d; eny_n2 <= aeny_n; eny_d2 <= aeny_d;
      exx_n2 <= aexx_n; exx_d2 <= aexx_d; exy_n2 <= aexy_n; exy_d2 <= aexy_d;
      pe_a   <= PW'(aenx_n) * PW'(aeny_d);
      pe_b   <= PW'(aeny_n) * PW'(aenx_d);
      px_a   <= PW'(aexx_n) * PW'(aexy_d);
      px_b   <= PW'(aexy_n) * PW'(aexx_d);
      rej2   <= rej;
      bx2 <= bx; by2 <= by; dx2 <= ddx; dy2 <= ddy;
    end
  end

  // stage 3: select the larger entry and the smaller exit
  logic                v3, rej3;
  logic signed [W-1:0] en_n3, en_d3, ex_n3, ex_d3;
  logic signed [W-1:0] bx3, by3, dx3, dy3;

  always_ff @(posedge clk) begin
    if (en) begin
      if (pe_a < pe_b) begin
        en_n3 <= eny_n2; en_d3 <= eny_d2;
      end else begin
        en_n3 <= enx_n2; en_d3 <= enx_d2;
      end
      if (px_b < px_a) begin
        ex_n3 <= exy_n2; ex_d3 <= exy_d2;
      end else begin
        ex_n3 <= exx_n2; ex_d3 <= exx_d2;
      end
      rej3 <= rej2;
      bx3 <= bx2; by3 <= by2; dx3 <= dx2; dy3 <= dy2;
    end
  end

  // stage 4: visibility cross products and base*den, num*d products
  logic                 v4, rej4;
  logic signed [PW-1:0] vis_a, vis_b;
  logic signed [PW-1:0] bsx, dsx, bsy, dsy, bex, dex, bey, dey;
  logic [N-1:0]         en_d4, ex_d4;

  always_ff @(posedge clk) begin
    if (en) begin
      vis_a <= PW'(en_n3) * PW'(ex_d3);
      vis_b <= PW'(ex_n3) * PW'(en_d3);
      bsx   <= PW'(bx3) * PW'(en_d3);
      dsx   <= PW'(en_n3) * PW'(dx3);
      bsy   <= PW'(by3) * PW'(en_d3);
      dsy   <= PW'(en_n3) * PW'(dy3);
      bex   <= PW'(bx3) * PW'(ex_d3);
      dex   <= PW'(ex_n3) * PW'(dx3);
      bey   <= PW'(by3) * PW'(ex_d3);
      dey   <= PW'(ex_n3) * PW'(dy3);
      en_d4 <= en_d3[N-1:0];
      ex_d4 <= ex_d3[N-1:0];
      rej4  <= rej3;
    end
  end

  // stage 5: sums, clamped at zero
  logic signed [PW-1:0] sum_sx, sum_sy, sum_ex, sum_ey;

  always_comb begin
    sum_sx = bsx + dsx;
    sum_sy = bsy + dsy;
    sum_ex = bex + dex;
    sum_ey = bey + dey;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_vis   <= !rej4 && (vis_a < vis_b);
      n_sx     <= sum_sx[PW-1] ? '0 : sum_sx[2*N-1:0];
      n_sy     <= sum_sy[PW-1] ? '0 : sum_sy[2*N-1:0];
      n_ex     <= sum_ex[PW-1] ? '0 : sum_ex[2*N-1:0];
      n_ey     <= sum_ey[PW-1] ? '0 : sum_ey[2*N-1:0];
      en_den_o <= en_d4;
      ex_den_o <= ex_d4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      s5_valid <= 1'b0;
    end else if (en) begin
      v2       <= s1_valid;
      v3       <= v2;
      v4       <= v3;
      s5_valid <= v4;
    end
  end

endmodule

// ----- sv/lcr_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module lcr_div #(
  parameter int N = lcr_pkg::COORD_BITS_DEF
) (
  input  logic           clk,
  input  logic           en,
  input  logic [2*N-1:0] num,
  input  logic [N-1:0]   den,
  output logic [N-1:0]   quo
);
  import lcr_pkg::*;

  logic [N-1:0] rem_q [N];
  logic [N-1:0] low_q [N];
  logic [N-1:0] den_q [N];
  logic [N-1:0] quo_q [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [N-1:0] rem_in, low_in, den_in, quo_in;
    logic [N:0]   cur, diff;
    logic         ge;

    if (k == 0) begin : g_first
      assign rem_in = num[2*N-1:N];
      assign low_in = num[N-1:0];
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign cur  = {rem_in, low_in[N-1]};
    assign diff = cur - {1'b0, den_in};
    assign ge   = (cur >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k] <= ge ? diff[N-1:0] : cur[N-1:0];
        low_q[k] <= {low_in[N-2:0], 1'b0};
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[N-2:0], ge};
      end
    end
  end

  assign quo = quo_q[N-1];

endmodule

// ----- sv/line_clip_to_rectangle.sv -----
// Top level: window registers, clip pipeline, dividers and output register.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_ready  | start_x start_y end_x end_y
//  out     | out_valid / out_ready| visible clipped_start_x/_y clipped_end_x/_y
//  cfg     | cfg_write            | cfg_index cfg_data
//
// One segment per cycle while the output is not stalled; five clip stages,
// one divider stage per quotient bit, then the output register.
// The whole pipeline advances together; it holds when the output register
// is full and not taken, so in_ready drops only then.
// Reset clears valid bits and loads the default window.
module line_clip_to_rectangle #(
  parameter int COORD_BITS = lcr_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [lcr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]          cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [COORD_BITS-1:0]          start_x,
  input  logic [COORD_BITS-1:0]          start_y,
  input  logic [COORD_BITS-1:0]          end_x,
  input  logic [COORD_BITS-1:0]          end_y,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           visible,
  output logic [COORD_BITS-1:0]          clipped_start_x,
  output logic [COORD_BITS-1:0]          clipped_start_y,
  output logic [COORD_BITS-1:0]          clipped_end_x,
  output logic [COORD_BITS-1:0]          clipped_end_y
);
  import lcr_pkg::*;

  localparam int N = COORD_BITS;

  logic [N-1:0] win_left, win_right, win_top, win_bottom;
  logic         en;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left   <= N'(LEFT_RST);
      win_right  <= N'(RIGHT_RST);
      win_top    <= N'(TOP_RST);
      win_bottom <= N'(BOTTOM_RST);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LEFT:   win_left   <= cfg_data;
        REG_RIGHT:  win_right  <= cfg_data;
        REG_TOP:    win_top    <= cfg_data;
        REG_BOTTOM: win_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                s1_valid, x_has, y_has, rej;
  logic signed [N+1:0] xen_num, xex_num, x_den, yen_num, yex_num, y_den;
  logic signed [N+1:0] bx, by, ddx, ddy;

  lcr_setup #(.N(N)) u_setup (
    .clk, .rst, .en, .in_valid,
    .win_left, .win_right, .win_top, .win_bottom,
    .x1(start_x), .y1(start_y), .x2(end_x), .y2(end_y),
    .s1_valid, .xen_num, .xex_num, .x_den, .x_has,
    .yen_num, .yex_num, .y_den, .y_has, .rej, .bx, .by, .ddx, .ddy
  );

  logic           s5_valid, s5_vis;
  logic [2*N-1:0] n_sx, n_sy, n_ex, n_ey;
  logic [N-1:0]   en_den, ex_den;

  lcr_param #(.N(N)) u_param (
    .clk, .rst, .en, .s1_valid,
    .xen_num, .xex_num, .x_den, .x_has,
    .yen_num, .yex_num, .y_den, .y_has, .rej, .bx, .by, .ddx, .ddy,
    .s5_valid, .s5_vis, .n_sx, .n_sy, .n_ex, .n_ey,
    .en_den_o(en_den), .ex_den_o(ex_den)
  );

  logic [N-1:0] q_sx, q_sy, q_ex, q_ey;

  lcr_div #(.N(N)) u_div_sx (.clk, .en, .num(n_sx), .den(en_den), .quo(q_sx));
  lcr_div #(.N(N)) u_div_sy (.clk, .en, .num(n_sy), .den(en_den), .quo(q_sy));
  lcr_div #(.N(N)) u_div_ex (.clk, .en, .num(n_ex), .den(ex_den), .quo(q_ex));
  lcr_div #(.N(N)) u_div_ey (.clk, .en, .num(n_ey), .den(ex_den), .quo(q_ey));

  // valid and visible flags run alongside the divider stages
  logic [N-1:0] dv_valid, dv_vis;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid <= '0;
    end else if (en) begin
      dv_valid <= {dv_valid[N-2:0], s5_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_vis <= {dv_vis[N-2:0], s5_vis};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      visible         <= dv_vis[N-1];
      clipped_start_x <= dv_vis[N-1] ? q_sx : '0;
      clipped_start_y <= dv_vis[N-1] ? q_sy : '0;
      clipped_end_x   <= dv_vis[N-1] ? q_ex : '0;
      clipped_end_y   <= dv_vis[N-1] ? q_ey : '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !visible |-> clipped_start_x == '0 && clipped_start_y == '0 &&
      clipped_end_x == '0 && clipped_end_y == '0)
    else $error("rejected segment carries nonzero points");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(dv_valid))
    else $error("pipeline moved during stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && dv_valid == '0)
    else $error("pipeline not empty after reset");
`endif

endmodule
